FILE: sv/fla_pkg.sv
// Package for the free-list block allocator: types, codes and sizing constants.
// Depends on nothing; used by every module under sv/.
package fla_pkg;

  localparam int HeapGranulesDef   = 128;
  localparam int HeaderGranulesDef = 3;
  localparam int MaxExtentsDef     = 64;
  localparam int GranuleBytes      = 8;
  localparam int AddrW             = 10;
  localparam int ReqW              = 11;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    FIT_FIRST = 1'b0,
    FIT_BEST  = 1'b1
  } fit_t;

  localparam logic [0:0] REG_FIT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_EDIT,
    S_OUT
  } state_t;

  // Shift command broadcast from the controller to the extent chain.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_WRITE,
    SH_INSERT,
    SH_REMOVE
  } shift_t;

endpackage

FILE: sv/fla_cell.sv
// One slot of the address-ordered extent chain; takes part in shift edits.
// Depends on fla_pkg.
module fla_cell
  import fla_pkg::*;
#(
  parameter int GW = 7,
  parameter int SW = 8,
  parameter logic [GW-1:0] RST_START = '0,
  parameter logic [SW-1:0] RST_SIZE  = '0
) (
  input  logic          clk,
  input  logic          rst,
  input  shift_t        cmd,
  input  logic          sel,      // this cell is the edit point
  input  logic          above,    // this cell lies past the edit point
  input  logic [GW-1:0] new_start,
  input  logic [SW-1:0] new_size,
  input  logic [GW-1:0] prev_start,
  input  logic [SW-1:0] prev_size,
  input  logic [GW-1:0] next_start,
  input  logic [SW-1:0] next_size,
  output logic [GW-1:0] start,
  output logic [SW-1:0] size
);

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= RST_START;
      size  <= RST_SIZE;
    end else begin
      case (cmd)
        SH_WRITE: begin
          if (sel) begin
            start <= new_start;
            size  <= new_size;
          end
        end
        SH_INSERT: begin
          if (sel) begin
            start <= new_start;
            size  <= new_size;
          end else if (above) begin
            start <= prev_start;
            size  <= prev_size;
          end
        end
        SH_REMOVE: begin
          if (sel || above) begin
            start <= next_start;
            size  <= next_size;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/fla_chain.sv
// Row of extent cells plus the registered read port that the scan uses to read one entry per cycle.
// Depends on fla_pkg and fla_cell.
module fla_chain
  import fla_pkg::*;
#(
  parameter int N  = 64,
  parameter int GW = 7,
  parameter int SW = 8,
  parameter logic [SW-1:0] INIT_SIZE = '0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  shift_t                cmd,
  input  logic [$clog2(N)-1:0]  pos,
  input  logic [GW-1:0]         new_start,
  input  logic [SW-1:0]         new_size,
  input  logic [$clog2(N)-1:0]  rd_idx,
  output logic [GW-1:0]         rd_start,
  output logic [SW-1:0]         rd_size
);

  localparam int IW = $clog2(N);

  logic [GW-1:0] st [N];
  logic [SW-1:0] sz [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [SW-1:0] RS = (i == 0) ? INIT_SIZE : '0;
    logic [GW-1:0] ps, ns;
    logic [SW-1:0] pz, nz;
    if (i == 0) begin : g_first
      assign ps = '0;
      assign pz = '0;
    end else begin : g_mid
      assign ps = st[i-1];
      assign pz = sz[i-1];
    end
    if (i == N - 1) begin : g_last
      assign ns = '0;
      assign nz = '0;
    end else begin : g_inner
      assign ns = st[i+1];
      assign nz = sz[i+1];
    end
    fla_cell #(.GW(GW), .SW(SW), .RST_START('0), .RST_SIZE(RS)) u_cell (
      .clk, .rst, .cmd,
      .sel       (pos == IW'(i)),
      .above     (IW'(i) > pos),
      .new_start, .new_size,
      .prev_start(ps), .prev_size(pz),
      .next_start(ns), .next_size(nz),
      .start     (st[i]),
      .size      (sz[i])
    );
  end

  // Registered read port for the scan.
  always_ff @(posedge clk) begin
    rd_start <= st[rd_idx];
    rd_size  <= sz[rd_idx];
  end

endmodule

FILE: sv/free_list_block_allocator.sv
// Top level of the free-list block allocator: handshake, APB register, scan control.
// Depends on fla_pkg and fla_chain.
//
// A heap of HEAP_GRANULES 8-byte granules. Free extents live in a row of
// MAX_EXTENTS cells kept in address order; an allocate scans the row one
// entry per cycle (first fit stops at the first match, best fit walks every
// live extent and keeps the earliest smallest one) and then removes the
// chosen extent, with every cell above it shifting down, or trims it in place.
// A free first scans for the insertion point, then inserts with the cells
// above shifting up; blocks are never coalesced. The result beat sits in an
// output register; the next input beat is taken once that result is taken.
// The fit_strategy register sits at address 0, bit 0.
module free_list_block_allocator
  import fla_pkg::*;
#(
  parameter int HEAP_GRANULES   = HeapGranulesDef,
  parameter int HEADER_GRANULES = HeaderGranulesDef,
  parameter int MAX_EXTENTS     = MaxExtentsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [ReqW-1:0]     request_bytes,
  input  logic [AddrW-1:0]    address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [AddrW-1:0]    payload_address
);

  localparam int GW  = $clog2(HEAP_GRANULES);
  localparam int SW  = $clog2(HEAP_GRANULES + 8 * GranuleBytes + 1) + 1;
  localparam int IW  = $clog2(MAX_EXTENTS);
  localparam int CW  = $clog2(MAX_EXTENTS + 1);
  localparam int AW  = AddrW;
  localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_GRANULES - HEADER_GRANULES);
  localparam logic [SW-1:0] HDR = SW'(HEADER_GRANULES);

  // Configuration register.
  logic fit;
  assign pready = 1'b1;
  assign prdata = {31'd0, fit};
  always_ff @(posedge clk) begin
    if (rst) begin
      fit <= FIT_FIRST;
    end else if (psel && penable && pwrite && paddr == REG_FIT) begin
      fit <= pwdata[0];
    end
  end

  // Per-block records.
  logic [SW-1:0] bsize [HEAP_GRANULES];
  logic [HEAP_GRANULES-1:0] balloc;

  state_t state, state_next;
  logic          cur_op;
  logic [SW-1:0] need, gran;
  logic [GW-1:0] blk;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          found;
  logic [IW-1:0] pick;
  logic [SW-1:0] best;
  logic [GW-1:0] best_start;
  logic          bad, full;
  logic          nul;         // free of the null address
  logic [SW-1:0] fsize;       // recorded size of the block being freed, in granules

  shift_t        cmd;
  logic [IW-1:0] pos;
  logic [GW-1:0] new_start;
  logic [SW-1:0] new_size;
  logic [GW-1:0] rd_start;
  logic [SW-1:0] rd_size;

  fla_chain #(.N(MAX_EXTENTS), .GW(GW), .SW(SW), .INIT_SIZE(INIT_SIZE)) u_chain (
    .clk, .rst, .cmd, .pos, .new_start, .new_size,
    .rd_idx  (idx[IW-1:0]),
    .rd_start,
    .rd_size
  );

  // Free-address decode, done at acceptance.
  logic [AW-1:0] gaddr;
  logic [AW:0]   bnum;
  logic          in_heap;
  always_comb begin
    gaddr   = address >> 3;
    bnum    = {1'b0, gaddr} - (AW+1)'(HEADER_GRANULES);
    in_heap = (gaddr >= AW'(HEADER_GRANULES)) && (bnum < (AW+1)'(HEAP_GRANULES));
  end

  logic take;
  assign in_ready = (state == S_IDLE) && !rst;
  assign take     = in_valid && in_ready;

  // The scan read port is registered; rd_* belongs to entry idx-1.
  logic          scan_live;   // rd_* holds a valid entry
  logic [IW-1:0] scan_at;
  logic          hit;
  assign hit = scan_live && (rd_size >= need);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (take) state_next = S_LOOK;
      S_LOOK: begin
        if (bad || full || nul) state_next = S_OUT;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        if (cur_op == OP_ALLOC) begin
          if (hit && fit == FIT_FIRST) state_next = S_EDIT;
          else if (!scan_live && idx > count) state_next = found ? S_EDIT : S_OUT;
        end else begin
          if ((scan_live && rd_start >= blk) || (!scan_live && idx > count))
            state_next = S_EDIT;
        end
      end
      S_EDIT: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Edit commands toward the chain.
  always_comb begin
    cmd       = SH_NONE;
    pos       = pick;
    new_start = '0;
    new_size  = '0;
    if (state == S_EDIT) begin
      if (cur_op == OP_ALLOC) begin
        if (best == need) begin
          cmd = SH_REMOVE;
        end else begin
          cmd       = SH_WRITE;
          new_start = best_start + GW'(need);
          new_size  = best - need;
        end
      end else begin
        cmd       = SH_INSERT;
        new_start = blk;
        new_size  = fsize;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= CW'(1);
      balloc    <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      scan_live <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (take) begin
            cur_op <= op;
            gran   <= SW'((request_bytes + ReqW'(GranuleBytes - 1)) >> 3);
            need   <= SW'((request_bytes + ReqW'(GranuleBytes - 1)) >> 3) + HDR;
            blk    <= bnum[GW-1:0];
            bad    <= (op == OP_FREE) && (address != '0) &&
                      ((address[2:0] != 3'd0) || !in_heap || !balloc[bnum[GW-1:0]]);
            full   <= (op == OP_FREE) && (address != '0) &&
                      (count >= CW'(MAX_EXTENTS));
            // Null free: skip straight to the done beat.
            nul       <= (op == OP_FREE) && (address == '0);
            idx       <= '0;
            found     <= 1'b0;
            scan_live <= 1'b0;
            pick      <= '0;
          end
        end
        S_LOOK: begin
          fsize     <= bsize[blk];
          idx       <= CW'(1);
          scan_live <= (count != '0);
          scan_at   <= '0;
        end
        S_SCAN: begin
          idx       <= idx + CW'(1);
          scan_at   <= idx[IW-1:0];
          scan_live <= (idx < count);
          if (cur_op == OP_ALLOC) begin
            if (hit && (!found || rd_size < best)) begin
              found      <= 1'b1;
              pick       <= scan_at;
              best       <= rd_size;
              best_start <= rd_start;
            end
          end else if (scan_live && rd_start < blk) begin
            pick <= scan_at + IW'(1);
          end else if (!scan_live && idx > count) begin
            pick <= count[IW-1:0];
          end
        end
        S_EDIT: begin
          if (cur_op == OP_ALLOC) begin
            if (best == need) count <= count - CW'(1);
            bsize[best_start]  <= (best == need) ? need : gran;
            balloc[best_start] <= 1'b1;
          end else begin
            count       <= count + CW'(1);
            balloc[blk] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (state_next == S_OUT && state != S_OUT) out_valid <= 1'b1;
      else if (state == S_OUT && out_ready) out_valid <= 1'b0;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (state != S_OUT && state_next == S_OUT) begin
      if (bad) begin
        status          <= ST_BADFREE;
        payload_address <= '0;
      end else if (full) begin
        status          <= ST_NOFIT;
        payload_address <= '0;
      end else if (cur_op == OP_FREE) begin
        status          <= ST_DONE;
        payload_address <= '0;
      end else if (state == S_EDIT || (state == S_SCAN && found) || (hit && fit == FIT_FIRST)) begin
        status          <= ST_DONE;
        payload_address <= AW'(({3'd0, best_start} + HDR) << 3);
      end else begin
        status          <= ST_NOFIT;
        payload_address <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_EXTENTS)) else $error("extent count overflow");
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("input taken while busy");
`endif

endmodule

FILE: tb/sv/tb_fla_checker.sv
// Scoreboard for the free-list block allocator: watches the APB port and both
// beat channels, predicts every result and compares it. Depends on fla_pkg.
`timescale 1ns / 100ps

module tb_fla_checker
  import fla_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [0:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             op,
  input  logic [ReqW-1:0]  request_bytes,
  input  logic [AddrW-1:0] address,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       status,
  input  logic [AddrW-1:0] payload_address,
  output int               fail_count,
  output int               pending
);

  localparam int Heap = HeapGranulesDef;
  localparam int Hdr  = HeaderGranulesDef;
  localparam int MaxX = MaxExtentsDef;

  typedef struct packed {
    status_t          st;
    logic [AddrW-1:0] pa;
  } alloc_result_t;

  alloc_result_t awaited_results[$];

  fit_t fit_mode;
  int   hole_start[MaxX];
  int   hole_size[MaxX];
  int   hole_count;
  int   block_size[Heap];
  bit   block_live[Heap];

  assign pending = awaited_results.size();

  task automatic heap_reset();
    fit_mode = FIT_FIRST;
    for (int i = 0; i < MaxX; i++) begin
      hole_start[i] = 0;
      hole_size[i] = 0;
    end
    for (int i = 0; i < Heap; i++) begin
      block_size[i] = 0;
      block_live[i] = 0;
    end
    hole_size[0] = Heap - Hdr;
    hole_count = 1;
  endtask

  task automatic heap_step(input op_t kind, input int bytes, input int addr,
                           output alloc_result_t r);
    int g, need, pick, best, start, size, blk, pos;
    bit found;
    r.st = ST_DONE;
    r.pa = '0;
    if (kind == OP_ALLOC) begin
      g = (bytes + GranuleBytes - 1) / GranuleBytes;
      need = g + Hdr;
      found = 0;
      pick = 0;
      best = 0;
      for (int i = 0; i < hole_count; i++) begin
        if (hole_size[i] >= need) begin
          if (fit_mode == FIT_FIRST) begin
            pick = i;
            found = 1;
            break;
          end
          if (!found || hole_size[i] < best) begin
            best = hole_size[i];
            pick = i;
            found = 1;
          end
        end
      end
      if (!found) begin
        r.st = ST_NOFIT;
        return;
      end
      start = hole_start[pick];
      size = hole_size[pick];
      if (size == need) begin
        // Exact fit: the extent vanishes and the block keeps the header too.
        for (int i = pick; i < hole_count - 1; i++) begin
          hole_start[i] = hole_start[i + 1];
          hole_size[i] = hole_size[i + 1];
        end
        hole_count--;
        block_size[start] = need;
      end else begin
        hole_start[pick] = start + need;
        hole_size[pick] = size - need;
        block_size[start] = g;
      end
      block_live[start] = 1;
      r.pa = AddrW'((start + Hdr) * GranuleBytes);
    end else begin
      if (addr == 0) return;
      if (addr % GranuleBytes != 0 || addr / GranuleBytes < Hdr) begin
        r.st = ST_BADFREE;
        return;
      end
      blk = addr / GranuleBytes - Hdr;
      if (blk >= Heap || !block_live[blk]) begin
        r.st = ST_BADFREE;
        return;
      end
      if (hole_count >= MaxX) begin
        r.st = ST_NOFIT;
        return;
      end
      pos = 0;
      while (pos < hole_count && hole_start[pos] < blk) pos++;
      for (int i = hole_count; i > pos; i--) begin
        hole_start[i] = hole_start[i - 1];
        hole_size[i] = hole_size[i - 1];
      end
      hole_start[pos] = blk;
      hole_size[pos] = block_size[blk];
      hole_count++;
      block_live[blk] = 0;
    end
  endtask

  initial begin
    fail_count = 0;
    heap_reset();
  end

  always @(posedge clk) begin
    alloc_result_t want, got;
    if (rst) begin
      heap_reset();
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_FIT)
        fit_mode = fit_t'(pwdata[0]);
      if (out_valid && out_ready) begin
        got.st = status_t'(status);
        got.pa = payload_address;
        if (awaited_results.size() == 0) begin
          $error("unexpected result beat: status %0d payload_address %0d", status,
                 payload_address);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.st != want.st) begin
            $error("status: expected %0d, actual %0d", want.st, got.st);
            fail_count++;
          end
          if (got.pa != want.pa) begin
            $error("payload_address: expected %0d, actual %0d", want.pa, got.pa);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        heap_step(op_t'(op), int'(request_bytes), int'(address), want);
        awaited_results.push_back(want);
      end
    end
  end

endmodule

FILE: tb/sv/tb_free_list_block_allocator.sv
// Top of the allocator testbench: clock, reset, APB writes, request stimulus
// and verdict. Depends on fla_pkg, tb_fla_checker and free_list_block_allocator.
`timescale 1ns / 100ps

module tb_free_list_block_allocator;
  import fla_pkg::*;

  localparam int CycleLimit = 400000;
  // Long enough for a scan over the whole extent row plus the control states.
  localparam int DrainCycles = MaxExtentsDef + 16;

  logic             clk;
  logic             rst;
  logic             psel, penable, pwrite;
  logic [0:0]       paddr;
  logic [31:0]      pwdata, prdata;
  logic             pready;
  logic             in_valid, in_ready;
  logic             op;
  logic [ReqW-1:0]  request_bytes;
  logic [AddrW-1:0] address;
  logic             out_valid, out_ready;
  logic [1:0]       status;
  logic [AddrW-1:0] payload_address;
  int               fail_count, pending;
  int               cycles;
  bit               bursty;

  // Payload addresses handed out and not yet freed, plus recently freed ones
  // that make good double-free attempts.
  logic [AddrW-1:0] live_blocks[$];
  logic [AddrW-1:0] freed_blocks[$];

  free_list_block_allocator u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .op, .request_bytes, .address,
    .out_valid, .out_ready, .status, .payload_address
  );

  tb_fla_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .op, .request_bytes, .address,
    .out_valid, .out_ready, .status, .payload_address,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Every successful allocate returns a nonzero payload address; remember it
  // so that later frees can target real blocks.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && payload_address != '0)
      live_blocks.push_back(payload_address);
  end

  // The result side stalls in random bursts while bursty is set.
  initial begin
    out_ready = 1'b0;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      if (bursty && $urandom_range(0, 1)) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  task automatic apb_write(input logic [0:0] where, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= where;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Present one beat and hold it until the block takes it. An idle burst
  // drops valid first; otherwise valid stays high from the previous beat.
  task automatic send_beat(input op_t kind, input int bytes, input int addr);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    request_bytes <= ReqW'(bytes);
    address <= AddrW'(addr);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic free_live(input bit pick_random);
    int k;
    logic [AddrW-1:0] a;
    if (live_blocks.size() == 0) begin
      send_beat(OP_FREE, 0, 0);
    end else begin
      k = pick_random ? $urandom_range(0, live_blocks.size() - 1) : 0;
      a = live_blocks[k];
      live_blocks.delete(k);
      freed_blocks.push_back(a);
      if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
      send_beat(OP_FREE, 0, int'(a));
    end
  endtask

  // Registers change only with no beat in flight: wait for every result,
  // then let a full scan's worth of cycles pass.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int dice;
    for (int n = 0; n < count; n++) begin
      dice = $urandom_range(0, 99);
      if (dice < 55) begin
        // Mostly heap-sized requests, now and then a larger one that may not fit.
        if ($urandom_range(0, 9) == 0) send_beat(OP_ALLOC, $urandom_range(65, 1024), 0);
        else send_beat(OP_ALLOC, $urandom_range(0, 64), 0);
      end else if (dice < 85) begin
        free_live(1'b1);
      end else if (dice < 90) begin
        send_beat(OP_FREE, 0, 0);
      end else if (dice < 95 && freed_blocks.size() != 0) begin
        send_beat(OP_FREE, 0,
                  int'(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]));
      end else begin
        send_beat(OP_FREE, 0, $urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    op = OP_ALLOC;
    request_bytes = '0;
    address = '0;
    bursty = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under first fit: request extremes and every free case.
    apb_write(REG_FIT, 32'(FIT_FIRST));
    send_beat(OP_ALLOC, 0, 0);        // block with no payload granules
    send_beat(OP_ALLOC, 1, 0);
    send_beat(OP_ALLOC, 8, 0);
    send_beat(OP_ALLOC, 9, 0);
    send_beat(OP_ALLOC, 1024, 0);     // more than the heap can hold
    send_beat(OP_ALLOC, 1023, 0);
    send_beat(OP_FREE, 0, 0);         // null free
    send_beat(OP_FREE, 0, 1023);      // misaligned
    send_beat(OP_FREE, 0, 8);         // below the first payload
    send_beat(OP_FREE, 0, 1016);      // aligned but never allocated
    quiesce();
    free_live(1'b0);
    free_live(1'b0);
    send_beat(OP_FREE, 0, int'(freed_blocks[0]));   // double free
    send_beat(OP_ALLOC, 0, 0);
    send_beat(OP_ALLOC, 16, 0);
    send_beat(OP_ALLOC, 400, 0);
    send_beat(OP_ALLOC, 500, 0);      // likely no longer fits
    quiesce();

    // The upper register address has nothing behind it.
    apb_write(1'b1, 32'hFFFF_FFFF);
    apb_write(REG_FIT, 32'(FIT_BEST));
    free_live(1'b1);
    free_live(1'b1);
    send_beat(OP_ALLOC, 8, 0);
    send_beat(OP_ALLOC, 0, 0);
    random_phase(150);
    quiesce();

    apb_write(REG_FIT, 32'(FIT_FIRST));
    random_phase(150);
    quiesce();

    apb_write(REG_FIT, 32'(FIT_BEST));
    random_phase(120);
    // Closing stretch runs flat out on both sides.
    bursty = 1'b0;
    random_phase(60);
    quiesce();

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
